[src/tlssni_pkg.sv]
// Shared types and constants for the TLS server-name split locator.
// No dependencies; used by tlssni_parser, tlssni_split and the top level.
package tlssni_pkg;

  // Width of every 16-bit count, offset and length at the ports.
  localparam int unsigned LenW   = 16;
  // Width of field positions that may run past a 16-bit buffer.
  localparam int unsigned FieldW = 18;

  // ClientHello layout constants
  localparam logic [7:0]  RecTypeHandshake = 8'h16;
  localparam logic [7:0]  RecVersionMajor  = 8'h03;
  localparam logic [7:0]  HsTypeClientHello = 8'h01;
  localparam logic [7:0]  SniNameTypeHost  = 8'h00;
  localparam logic [15:0] ExtTypeServerName = 16'h0000;
  // Record header (5) + handshake header (4) + version and random (34)
  localparam logic [FieldW-1:0] SessionIdPos = FieldW'(5 + 4 + 34);
  localparam logic [FieldW-1:0] VersionPos   = FieldW'(1);
  localparam logic [FieldW-1:0] HsTypePos    = FieldW'(5);
  localparam logic [LenW-1:0]   MinTlsBytes  = LenW'(5);

  // Configuration register indexes
  localparam logic CfgSplitInName = 1'b0;
  localparam logic CfgFixedSplit  = 1'b1;

  // Parse outcome of a buffer, taken on its final byte
  typedef struct packed {
    logic [LenW-1:0] buf_len;
    logic            failed_at_type;
    logic            name_ok;
    logic [LenW-1:0] name_off;
    logic [LenW-1:0] name_len;
  } parse_status_t;

endpackage

[src/tlssni_parser.sv]
// Byte-by-byte ClientHello walker: holds the parse state of one buffer.
// Depends on tlssni_pkg.
module tlssni_parser #(
  parameter int unsigned MAX_BUFFER_BYTES = 65535
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic [7:0]              data_i,
  input  logic                    last_i,
  output tlssni_pkg::parse_status_t status_o
);

  localparam int unsigned PosW = $clog2(MAX_BUFFER_BYTES + 1);
  localparam logic [PosW-1:0] MaxPos = PosW'(MAX_BUFFER_BYTES);
  localparam int unsigned FW = tlssni_pkg::FieldW;
  localparam int unsigned LW = tlssni_pkg::LenW;

  localparam logic [3:0] PhType    = 4'd0;
  localparam logic [3:0] PhVer     = 4'd1;
  localparam logic [3:0] PhHs      = 4'd2;
  localparam logic [3:0] PhSid     = 4'd3;
  localparam logic [3:0] PhCsHi    = 4'd4;
  localparam logic [3:0] PhCsLo    = 4'd5;
  localparam logic [3:0] PhComp    = 4'd6;
  localparam logic [3:0] PhExtHi   = 4'd7;
  localparam logic [3:0] PhExtLo   = 4'd8;
  localparam logic [3:0] PhExtHdr  = 4'd9;
  localparam logic [3:0] PhSniType = 4'd10;
  localparam logic [3:0] PhSniNlHi = 4'd11;
  localparam logic [3:0] PhSniNlLo = 4'd12;
  localparam logic [3:0] PhDone    = 4'd13;

  logic [PosW-1:0] pos_q, pos_d;
  logic [3:0]      phase_q, phase_d;
  logic [FW-1:0]   nfp_q, nfp_d;
  logic [7:0]      hold_q, hold_d;
  logic [FW-1:0]   ext_end_q, ext_end_d;
  logic [15:0]     etype_q, etype_d;
  logic [15:0]     elen_q, elen_d;
  logic [LW-1:0]   foff_q, foff_d;
  logic [LW-1:0]   flen_q, flen_d;
  logic            failed_q, failed_d;

  logic [FW-1:0]   pos_w, pos_nx, hdr_p, word_w;
  logic [15:0]     word;
  logic [LW:0]     name_end;

  always_comb begin
    pos_d     = pos_q;
    phase_d   = phase_q;
    nfp_d     = nfp_q;
    hold_d    = hold_q;
    ext_end_d = ext_end_q;
    etype_d   = etype_q;
    elen_d    = elen_q;
    foff_d    = foff_q;
    flen_d    = flen_q;
    failed_d  = failed_q;
    pos_w     = FW'(pos_q);
    pos_nx    = pos_w + FW'(1);
    word      = {hold_q, data_i};
    word_w    = FW'(word);
    hdr_p     = '0;

    if (pos_q < MaxPos) begin
      pos_d = pos_q + PosW'(1);
      if (!failed_q && phase_q != PhDone) begin
        if (phase_q == PhExtHdr) begin
          if (pos_w >= nfp_q) begin
            // four header bytes shift through type and length
            etype_d = {etype_q[7:0], elen_q[15:8]};
            elen_d  = {elen_q[7:0], data_i};
            if (pos_w == nfp_q + FW'(3)) begin
              if (etype_d == tlssni_pkg::ExtTypeServerName) begin
                if (pos_nx + FW'(5) > ext_end_q) begin
                  failed_d = 1'b1;
                end else begin
                  nfp_d   = pos_nx + FW'(2);
                  phase_d = PhSniType;
                end
              end else begin
                hdr_p = pos_nx + FW'(elen_d);
                nfp_d = hdr_p;
                if (hdr_p + FW'(4) > ext_end_q) failed_d = 1'b1;
              end
            end
          end
        end else if (pos_w == nfp_q) begin
          unique case (phase_q)
            PhType: begin
              if (data_i != tlssni_pkg::RecTypeHandshake) failed_d = 1'b1;
              else begin
                nfp_d = tlssni_pkg::VersionPos; phase_d = PhVer;
              end
            end
            PhVer: begin
              if (data_i != tlssni_pkg::RecVersionMajor) failed_d = 1'b1;
              else begin
                nfp_d = tlssni_pkg::HsTypePos; phase_d = PhHs;
              end
            end
            PhHs: begin
              if (data_i != tlssni_pkg::HsTypeClientHello) failed_d = 1'b1;
              else begin
                nfp_d = tlssni_pkg::SessionIdPos; phase_d = PhSid;
              end
            end
            PhSid: begin
              nfp_d = pos_nx + FW'(data_i); phase_d = PhCsHi;
            end
            PhCsHi: begin
              hold_d = data_i; nfp_d = pos_nx; phase_d = PhCsLo;
            end
            PhCsLo: begin
              nfp_d = pos_nx + word_w; phase_d = PhComp;
            end
            PhComp: begin
              nfp_d = pos_nx + FW'(data_i); phase_d = PhExtHi;
            end
            PhExtHi: begin
              hold_d = data_i; nfp_d = pos_nx; phase_d = PhExtLo;
            end
            PhExtLo: begin
              ext_end_d = pos_nx + word_w;
              etype_d   = '0;
              elen_d    = '0;
              nfp_d     = pos_nx;
              if (pos_nx + FW'(4) > ext_end_d) failed_d = 1'b1;
              else phase_d = PhExtHdr;
            end
            PhSniType: begin
              if (data_i != tlssni_pkg::SniNameTypeHost) failed_d = 1'b1;
              else begin
                nfp_d = pos_nx; phase_d = PhSniNlHi;
              end
            end
            PhSniNlHi: begin
              hold_d = data_i; nfp_d = pos_nx; phase_d = PhSniNlLo;
            end
            PhSniNlLo: begin
              if (word == '0 || pos_nx + word_w > ext_end_q) failed_d = 1'b1;
              else begin
                foff_d  = LW'(pos_nx);
                flen_d  = word;
                phase_d = PhDone;
              end
            end
            default: failed_d = 1'b1;
          endcase
        end
      end
    end
  end

  always_comb begin
    name_end                = {1'b0, foff_d} + {1'b0, flen_d};
    status_o.buf_len        = LW'(pos_d);
    status_o.failed_at_type = failed_d && (phase_d == PhType);
    status_o.name_ok        = !failed_d && (phase_d == PhDone) &&
                              (name_end <= {1'b0, LW'(pos_d)});
    status_o.name_off       = foff_d;
    status_o.name_len       = flen_d;
  end

  // Parse state returns to its reset value after the final byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      phase_q   <= PhType;
      nfp_q     <= '0;
      hold_q    <= '0;
      ext_end_q <= '0;
      etype_q   <= '0;
      elen_q    <= '0;
      foff_q    <= '0;
      flen_q    <= '0;
      failed_q  <= 1'b0;
    end else if (en_i) begin
      if (last_i) begin
        pos_q     <= '0;
        phase_q   <= PhType;
        nfp_q     <= '0;
        hold_q    <= '0;
        ext_end_q <= '0;
        etype_q   <= '0;
        elen_q    <= '0;
        foff_q    <= '0;
        flen_q    <= '0;
        failed_q  <= 1'b0;
      end else begin
        pos_q     <= pos_d;
        phase_q   <= phase_d;
        nfp_q     <= nfp_d;
        hold_q    <= hold_d;
        ext_end_q <= ext_end_d;
        etype_q   <= etype_d;
        elen_q    <= elen_d;
        foff_q    <= foff_d;
        flen_q    <= flen_d;
        failed_q  <= failed_d;
      end
    end
  end

endmodule

[src/tlssni_split.sv]
// Split-point choice from the parse outcome and the split configuration.
// Depends on tlssni_pkg.
module tlssni_split (
  input  tlssni_pkg::parse_status_t   status_i,
  input  logic                        split_in_name_i,
  input  logic [tlssni_pkg::LenW-1:0] fixed_split_position_i,
  output logic                        split_valid_o,
  output logic [tlssni_pkg::LenW-1:0] split_position_o
);

  logic tls, fixed_ok;
  logic [tlssni_pkg::LenW-1:0] split;

  always_comb begin
    tls      = (status_i.buf_len >= tlssni_pkg::MinTlsBytes) &&
               !status_i.failed_at_type;
    fixed_ok = (fixed_split_position_i != '0) &&
               (fixed_split_position_i < status_i.buf_len);
    split    = '0;
    if (tls) begin
      if (status_i.name_ok) begin
        // a found name ends inside the buffer, so the middle fits 16 bits
        if (split_in_name_i)
          split = status_i.name_off + (status_i.name_len >> 1);
        else if (fixed_ok) split = fixed_split_position_i;
        else split = status_i.name_off;
      end else if (fixed_ok) begin
        split = fixed_split_position_i;
      end
    end
    split_valid_o    = (split != '0);
    split_position_o = split;
  end

endmodule

[src/tls_sni_split_locator.sv]
// Top level of the TLS ClientHello server-name locator and split chooser.
// Depends on tlssni_pkg, tlssni_parser and tlssni_split.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one buffer byte per beat,
//   with last_byte_i on the final beat. Output channel (out_valid_o /
//   out_stall_i) carries one result beat per buffer, none for other bytes.
//   Configuration writes (cfg_valid_i / cfg_ready_o) set split_in_name
//   (index 0) and fixed_split_position (index 1); ready is always high.
//   Path: a final byte, once accepted, passes the input register, then the
//   parse and split logic, into the result register.
//   Throughput: one byte per cycle unless in_stall_o is raised; the parser
//   updates all its state from each registered byte, so nothing iterates.
//   Stall: the result register holds while out_stall_i is high. Non-final
//   bytes keep flowing; a final byte waits in the input register until the
//   result register is free, and in_stall_o is raised behind it.
//   Reset: asynchronous, active low; clears the parse state, empties both
//   registers and sets both configuration registers to zero. No clearing
//   pass is needed. Bytes past MAX_BUFFER_BYTES are not parsed or counted.
module tls_sni_split_locator #(
  parameter int unsigned MAX_BUFFER_BYTES = 65535
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        name_found_o,
  output logic [15:0] name_offset_o,
  output logic [15:0] name_length_o,
  output logic        split_valid_o,
  output logic [15:0] split_position_o,
  output logic [15:0] buffer_length_o,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  tlssni_pkg::parse_status_t status;

  logic        in_vld_q;
  logic [7:0]  byte_q;
  logic        last_q;
  logic        out_free, proc_en, in_accept;

  logic        split_in_name_q;
  logic [15:0] fixed_split_q;

  logic        split_valid;
  logic [15:0] split_position;

  logic        out_vld_q;
  logic        found_q, split_vld_q;
  logic [15:0] off_q, len_q, split_q, buf_len_q;

  // A final byte needs the result slot; other bytes never do.
  assign out_free   = !out_vld_q || !out_stall_i;
  assign proc_en    = in_vld_q && (!last_q || out_free);
  assign in_stall_o = in_vld_q && !proc_en;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_accept) begin
      in_vld_q <= 1'b1;
    end else if (proc_en) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      byte_q <= data_byte_i;
      last_q <= last_byte_i;
    end
  end

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      split_in_name_q <= 1'b0;
      fixed_split_q   <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        tlssni_pkg::CfgSplitInName: split_in_name_q <= cfg_data_i[0];
        tlssni_pkg::CfgFixedSplit:  fixed_split_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tlssni_parser #(
    .MAX_BUFFER_BYTES(MAX_BUFFER_BYTES)
  ) u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (proc_en),
    .data_i  (byte_q),
    .last_i  (last_q),
    .status_o(status)
  );

  tlssni_split u_split (
    .status_i              (status),
    .split_in_name_i       (split_in_name_q),
    .fixed_split_position_i(fixed_split_q),
    .split_valid_o         (split_valid),
    .split_position_o      (split_position)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (proc_en && last_q) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_en && last_q) begin
      found_q     <= status.name_ok;
      off_q       <= status.name_ok ? status.name_off : '0;
      len_q       <= status.name_ok ? status.name_len : '0;
      split_vld_q <= split_valid;
      split_q     <= split_position;
      buf_len_q   <= status.buf_len;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign name_found_o     = found_q;
  assign name_offset_o    = off_q;
  assign name_length_o    = len_q;
  assign split_valid_o    = split_vld_q;
  assign split_position_o = split_q;
  assign buffer_length_o  = buf_len_q;

endmodule

[tb/tb_tls_sni_split_locator.sv]
// Self-checking testbench for tls_sni_split_locator: byte-level predictor and scoreboard
// in one small class, tasks for the byte and register channels, a result monitor block.
// Depends on tlssni_pkg and the tls_sni_split_locator RTL.
`timescale 1ns / 100ps

module tb_tls_sni_split_locator;
  import tlssni_pkg::*;

  localparam int unsigned ClkPeriod   = 10;
  localparam int unsigned MaxBufBytes = 65535;
  localparam int unsigned CycleLimit  = 1_000_000;
  // settling margin once the last owed result has been checked
  localparam int unsigned DrainCycles = 8;
  // long hold-off of the result side, enough to fill both registers
  localparam int unsigned HoldCycles  = 400;

  // Walk position inside the ClientHello
  typedef enum logic [3:0] {
    WkRecType, WkVersion, WkHsType, WkSidLen, WkSuitesHi, WkSuitesLo, WkCompLen,
    WkExtLenHi, WkExtLenLo, WkExtHeader, WkNameType, WkNameLenHi, WkNameLenLo, WkDone
  } walk_phase_e;

  // Ways a generated ClientHello is spoilt
  typedef enum logic [3:0] {
    FlawNone, FlawRecType, FlawVersion, FlawHsType, FlawTruncate, FlawCorrupt,
    FlawNameType, FlawNameZero, FlawNameLong, FlawListShort, FlawListLong, FlawNoName
  } hello_flaw_e;

  typedef struct packed {
    logic            found;
    logic [LenW-1:0] name_offset;
    logic [LenW-1:0] name_length;
    logic            split;
    logic [LenW-1:0] split_pos;
    logic [LenW-1:0] buf_len;
  } sni_verdict_t;

  // Follows the block byte by byte and holds the verdicts still owed by it
  class sni_split_scoreboard;
    logic              split_mid;
    logic [LenW-1:0]   fixed_split;
    logic [16:0]       byte_count;
    walk_phase_e       walk_phase;
    logic [FieldW-1:0] next_pos;
    logic [7:0]        hi_hold;
    logic [FieldW-1:0] ext_end;
    logic [15:0]       ent_type;
    logic [15:0]       ent_len;
    logic [LenW-1:0]   name_off;
    logic [LenW-1:0]   name_len;
    logic              walk_failed;
    sni_verdict_t      verdicts[$];
    int unsigned       mismatches;
    int unsigned       verdicts_made;
    int unsigned       names_found;
    int unsigned       splits_made;

    function void clear_walk();
      byte_count  = '0;
      walk_phase  = WkRecType;
      next_pos    = '0;
      hi_hold     = '0;
      ext_end     = '0;
      ent_type    = '0;
      ent_len     = '0;
      name_off    = '0;
      name_len    = '0;
      walk_failed = 1'b0;
    endfunction

    function void reset_all();
      clear_walk();
      split_mid   = 1'b0;
      fixed_split = '0;
    endfunction

    function void write_reg(logic idx, logic [15:0] v);
      if (idx == CfgSplitInName) split_mid = v[0];
      else fixed_split = v;
    endfunction

    // next extension header starts at p, unless the list has no room for one
    function void open_ext_header(logic [FieldW-1:0] p);
      next_pos = p;
      if (p + 4 > ext_end) walk_failed = 1'b1;
      else walk_phase = WkExtHeader;
    endfunction

    function void walk_byte(logic [FieldW-1:0] p, logic [7:0] b);
      logic [FieldW-1:0] q;
      logic [15:0]       n;
      if (walk_failed || walk_phase == WkDone) return;
      if (walk_phase == WkExtHeader) begin
        if (p < next_pos) return;
        ent_type = {ent_type[7:0], ent_len[15:8]};
        ent_len  = {ent_len[7:0], b};
        if (p != next_pos + 3) return;
        if (ent_type == ExtTypeServerName) begin
          q = p + 1;
          if (q + 5 > ext_end) walk_failed = 1'b1;
          else begin
            // skip the two-byte server-name list length
            next_pos   = q + 2;
            walk_phase = WkNameType;
          end
        end else begin
          open_ext_header(p + 1 + ent_len);
        end
        return;
      end
      if (p != next_pos) return;
      case (walk_phase)
        WkRecType: begin
          if (b != RecTypeHandshake) walk_failed = 1'b1;
          else begin next_pos = VersionPos; walk_phase = WkVersion; end
        end
        WkVersion: begin
          if (b != RecVersionMajor) walk_failed = 1'b1;
          else begin next_pos = HsTypePos; walk_phase = WkHsType; end
        end
        WkHsType: begin
          if (b != HsTypeClientHello) walk_failed = 1'b1;
          else begin next_pos = SessionIdPos; walk_phase = WkSidLen; end
        end
        WkSidLen: begin
          next_pos = p + 1 + b; walk_phase = WkSuitesHi;
        end
        WkSuitesHi: begin
          hi_hold = b; next_pos = p + 1; walk_phase = WkSuitesLo;
        end
        WkSuitesLo: begin
          next_pos = p + 1 + {hi_hold, b}; walk_phase = WkCompLen;
        end
        WkCompLen: begin
          next_pos = p + 1 + b; walk_phase = WkExtLenHi;
        end
        WkExtLenHi: begin
          hi_hold = b; next_pos = p + 1; walk_phase = WkExtLenLo;
        end
        WkExtLenLo: begin
          ext_end  = p + 1 + {hi_hold, b};
          ent_type = '0;
          ent_len  = '0;
          open_ext_header(p + 1);
        end
        WkNameType: begin
          if (b != SniNameTypeHost) walk_failed = 1'b1;
          else begin next_pos = p + 1; walk_phase = WkNameLenHi; end
        end
        WkNameLenHi: begin
          hi_hold = b; next_pos = p + 1; walk_phase = WkNameLenLo;
        end
        WkNameLenLo: begin
          n = {hi_hold, b};
          if (n == '0 || p + 1 + n > ext_end) walk_failed = 1'b1;
          else begin
            name_off   = LenW'(p + 1);
            name_len   = n;
            walk_phase = WkDone;
          end
        end
        default: walk_failed = 1'b1;
      endcase
    endfunction

    // one accepted byte beat; a final byte owes one verdict
    function void note_byte(logic [7:0] b, logic last);
      logic [16:0]  total;
      logic [16:0]  split_at;
      logic         is_hello;
      logic         found;
      logic         fixed_ok;
      sni_verdict_t v;
      if (byte_count < MaxBufBytes) begin
        walk_byte(FieldW'(byte_count), b);
        byte_count++;
      end
      if (!last) return;
      total    = byte_count;
      is_hello = total >= MinTlsBytes && !(walk_failed && walk_phase == WkRecType);
      found    = !walk_failed && walk_phase == WkDone &&
                 ({1'b0, name_off} + name_len) <= total;
      fixed_ok = fixed_split != '0 && fixed_split < total;
      split_at = '0;
      if (is_hello) begin
        if (found) begin
          if (split_mid) split_at = name_off + name_len / 2;
          else if (fixed_ok) split_at = fixed_split;
          else split_at = name_off;
        end else if (fixed_ok) begin
          split_at = fixed_split;
        end
      end
      v.found       = found;
      v.name_offset = found ? name_off : '0;
      v.name_length = found ? name_len : '0;
      v.split       = split_at != '0;
      v.split_pos   = split_at[15:0];
      v.buf_len     = total[15:0];
      verdicts.push_back(v);
      verdicts_made++;
      if (found) names_found++;
      if (v.split) splits_made++;
      clear_walk();
    endfunction

    function void cmp_field(string what, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        mismatches++;
      end
    endfunction

    function void check_verdict(sni_verdict_t got);
      sni_verdict_t want;
      if (verdicts.size() == 0) begin
        $display("%0t: result beat with nothing expected, expected none, actual %p",
                 $time, got);
        mismatches++;
        return;
      end
      want = verdicts.pop_front();
      cmp_field("name_found", want.found, got.found);
      cmp_field("name_offset", want.name_offset, got.name_offset);
      cmp_field("name_length", want.name_length, got.name_length);
      cmp_field("split_valid", want.split, got.split);
      cmp_field("split_position", want.split_pos, got.split_pos);
      cmp_field("buffer_length", want.buf_len, got.buf_len);
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // Block ports; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i = '0;
  logic        last_byte_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        name_found_o;
  logic [15:0] name_offset_o;
  logic [15:0] name_length_o;
  logic        split_valid_o;
  logic [15:0] split_position_o;
  logic [15:0] buffer_length_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = 1'b0;
  logic [15:0] cfg_data_i  = '0;

  sni_split_scoreboard sb = new();

  // Idling odds in percent per cycle, set per phase
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        pressure_go   = 1'b0;
  logic        holding       = 1'b0;
  int unsigned bytes_sent    = 0;
  int unsigned cycles        = 0;

  // Buffer being built before it is sent, one byte per beat
  logic [7:0] frame[$];

  tls_sni_split_locator #(
    .MAX_BUFFER_BYTES(MaxBufBytes)
  ) dut (.*);

  always begin
    clk_i = 1'b0;
    #(ClkPeriod / 2);
    clk_i = 1'b1;
    #(ClkPeriod / 2);
  end

  // Run guard: a hung handshake or a lost result ends here
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("tb_tls_sni_split_locator: done, errors");
      $finish;
    end
  end

  // Result side: random stall, or a solid hold-off when asked for
  always @(posedge clk_i) begin
    if (holding) out_stall_i <= 1'b1;
    else out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // Hold-off counted here; the byte side keeps offering beats meanwhile, so
  // the result register and the final byte behind it both fill and the
  // block pushes back on its input.
  initial begin : result_hold_off
    wait (pressure_go);
    @(posedge clk_i);
    holding <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    holding <= 1'b0;
  end

  // Every result beat taken is checked against the oldest pending verdict
  always @(posedge clk_i) begin : result_monitor
    sni_verdict_t seen;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      seen.found       = name_found_o;
      seen.name_offset = name_offset_o;
      seen.name_length = name_length_o;
      seen.split       = split_valid_o;
      seen.split_pos   = split_position_o;
      seen.buf_len     = buffer_length_o;
      sb.check_verdict(seen);
    end
  end

  // ---------------------------------------------------------------------------
  // Buffer builders
  // ---------------------------------------------------------------------------
  function automatic void put16(int unsigned v);
    frame.push_back(v[15:8]);
    frame.push_back(v[7:0]);
  endfunction

  function automatic void put_random(int unsigned n);
    repeat (n) frame.push_back(8'($urandom_range(255)));
  endfunction

  function automatic logic [7:0] pick_other(logic [7:0] avoid);
    logic [7:0] v;
    v = 8'($urandom_range(255));
    if (v == avoid) v = ~avoid;
    return v;
  endfunction

  // ClientHello with an optional extension ahead of the server name, then
  // one spoilt field or none. pad_n < 0 leaves out the leading extension.
  function automatic void build_hello(int unsigned sid_n, int unsigned suite_n,
                                      int unsigned comp_n, int pad_n,
                                      int unsigned name_n, hello_flaw_e flaw);
    int unsigned len_at;
    int unsigned total;
    int unsigned name_field;
    int unsigned tail_n;
    int unsigned cut;
    frame.delete();
    frame.push_back(RecTypeHandshake);
    frame.push_back(RecVersionMajor);
    put_random(3);
    frame.push_back(HsTypeClientHello);
    put_random(3 + 34);
    frame.push_back(8'(sid_n));
    put_random(sid_n);
    put16(suite_n);
    put_random(suite_n);
    frame.push_back(8'(comp_n));
    put_random(comp_n);
    len_at = frame.size();
    put16(0);
    if (pad_n >= 0) begin
      put16($urandom_range(1, 16'hFFFF));
      put16(pad_n);
      put_random(pad_n);
    end
    if (flaw != FlawNoName) begin
      put16(ExtTypeServerName);
      put16(name_n + 5);
      put16(name_n + 3);
      frame.push_back(flaw == FlawNameType ? pick_other(SniNameTypeHost) : SniNameTypeHost);
      name_field = name_n;
      if (flaw == FlawNameZero) name_field = 0;
      if (flaw == FlawNameLong) name_field = name_n + $urandom_range(1, 600);
      put16(name_field);
      put_random(name_n);
    end
    if (flaw == FlawNone && $urandom_range(3) == 0) begin
      tail_n = $urandom_range(8);
      put16($urandom_range(1, 16'hFFFF));
      put16(tail_n);
      put_random(tail_n);
    end
    // patch the extension total now the list is known
    total = frame.size() - len_at - 2;
    if (flaw == FlawListShort) total = $urandom_range(total - 1);
    if (flaw == FlawListLong) total = total + $urandom_range(1, 500);
    frame[len_at]     = total[15:8];
    frame[len_at + 1] = total[7:0];
    case (flaw)
      FlawRecType: frame[0] = pick_other(RecTypeHandshake);
      FlawVersion: frame[1] = pick_other(RecVersionMajor);
      FlawHsType:  frame[5] = pick_other(HsTypeClientHello);
      FlawTruncate: begin
        cut = $urandom_range(1, frame.size() - 1);
        while (frame.size() > cut) void'(frame.pop_back());
      end
      FlawCorrupt: begin
        if ($urandom_range(1)) frame[$urandom_range(5)] = 8'($urandom_range(255));
        else frame[$urandom_range(frame.size() - 1)] = 8'($urandom_range(255));
      end
      default: ;
    endcase
  endfunction

  function automatic void build_noise(int unsigned n);
    frame.delete();
    put_random(n);
    if ($urandom_range(1)) frame[0] = RecTypeHandshake;
  endfunction

  function automatic void build_fill(int unsigned n, logic [7:0] v);
    frame.delete();
    repeat (n) frame.push_back(v);
  endfunction

  // Mostly well-formed hellos with random content, the rest spoilt or noise
  function automatic void random_frame();
    int unsigned pick;
    int unsigned sid_n;
    hello_flaw_e flaw;
    pick = $urandom_range(99);
    flaw = FlawNone;
    if (pick < 15) begin
      build_noise($urandom_range(1, 12));
    end else begin
      if (pick >= 70) flaw = hello_flaw_e'($urandom_range(1, flaw.num() - 1));
      sid_n = ($urandom_range(7) == 0) ? 32 : $urandom_range(8);
      build_hello(sid_n, 2 * $urandom_range(3), $urandom_range(2),
                  $urandom_range(1) ? int'($urandom_range(12)) : -1,
                  ($urandom_range(15) == 0) ? $urandom_range(25, 300) : $urandom_range(1, 24),
                  flaw);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Channel tasks
  // ---------------------------------------------------------------------------
  task automatic send_byte(logic [7:0] b, logic last);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= last;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    sb.note_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_frame();
    foreach (frame[i]) send_byte(frame[i], i == frame.size() - 1);
  endtask

  task automatic write_cfg(logic idx, logic [15:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (cfg_ready_o !== 1'b1) @(posedge clk_i);
    sb.write_reg(idx, value);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Stop offering beats, let every owed verdict arrive, then settle
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.verdicts.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic run_random(int unsigned min_bytes, int unsigned min_verdicts);
    int unsigned bytes0;
    int unsigned made0;
    bytes0 = bytes_sent;
    made0  = sb.verdicts_made;
    while (bytes_sent - bytes0 < min_bytes || sb.verdicts_made - made0 < min_verdicts) begin
      random_frame();
      send_frame();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned snd;
    int unsigned rcv;
    logic        mid;
    logic [15:0] fixed_pos;
    hello_flaw_e flaw;

    sb.reset_all();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // registers at their reset values, written anyway
    write_cfg(CfgSplitInName, 16'h0000);
    write_cfg(CfgFixedSplit, 16'h0000);

    send_idle_pct = 33;
    recv_idle_pct = 79;

    // Directed: runt buffers, wrong first byte, extreme byte values
    build_fill(1, RecTypeHandshake);
    send_frame();
    frame = '{RecTypeHandshake, RecVersionMajor, HsTypeClientHello, 8'h00};
    send_frame();
    frame = '{RecTypeHandshake, RecVersionMajor, 8'h01, 8'h00, 8'h40};
    send_frame();
    build_fill(8, 8'hFF);
    send_frame();
    build_fill(8, 8'h00);
    send_frame();

    // Directed: well-formed hellos, smallest to widest length fields
    build_hello(0, 0, 0, -1, 1, FlawNone);
    send_frame();
    build_hello(32, 2, 1, 0, 24, FlawNone);
    send_frame();
    build_hello(255, 300, 255, 5, 60, FlawNone);
    send_frame();

    // Directed: each way of spoiling a hello
    for (int f = 1; f < flaw.num(); f++) begin
      build_hello(4, 2, 1, 3, 12, hello_flaw_e'(f));
      send_frame();
    end

    // Directed: overlong buffer, name ending on the last counted byte and
    // a few beats past the counting limit that must be ignored
    build_hello(0, 0, 0, 65273, 200, FlawNone);
    put_random(10);
    send_frame();
    wait_drained();

    // Random phases: idling mode changes every two, register setting each
    for (int s = 0; s < 6; s++) begin
      case (s / 2)
        0:       begin snd = 33; rcv = 79; end
        1:       begin snd = 79; rcv = 33; end
        default: begin snd = 0;  rcv = 0;  end
      endcase
      case (s)
        0:       begin mid = 1'b1; fixed_pos = 16'h0000; end
        1:       begin mid = 1'b0; fixed_pos = 16'd60; end
        2:       begin mid = 1'b0; fixed_pos = 16'hFFFF; end
        3:       begin mid = 1'b1; fixed_pos = 16'($urandom_range(1, 200)); end
        4:       begin mid = 1'b0; fixed_pos = 16'h0001; end
        default: begin mid = 1'b0; fixed_pos = 16'($urandom_range(120)); end
      endcase
      // upper data bits are don't-care for the one-bit register
      write_cfg(CfgSplitInName, {15'($urandom), mid});
      write_cfg(CfgFixedSplit, fixed_pos);
      send_idle_pct = snd;
      recv_idle_pct = rcv;
      if (s == 4) pressure_go = 1'b1;
      run_random(190, 6);
      wait_drained();
    end

    $display("covered %0d byte beats, %0d buffers with %0d names located",
             bytes_sent, sb.verdicts_made, sb.names_found);
    $display("and %0d split points, across six register settings and three idling modes",
             sb.splits_made);
    if (sb.mismatches == 0 && sb.verdicts.size() == 0) begin
      $display("tb_tls_sni_split_locator: done, clean");
    end else begin
      $display("tb_tls_sni_split_locator: done, errors");
    end
    $finish;
  end

endmodule
